// ===== hdl/phc_pkg.sv =====
// ----------------------------------------------------------------------------
// phc_pkg
// Shared types, codes and the protocol name ROM of the peer handshake checker.
// ----------------------------------------------------------------------------
`default_nettype none

package phc_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 64;

	localparam logic [CFG_INDEX_W-1:0] REG_HASH_HIGH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HASH_MID  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HASH_LOW  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RESERVED  = 2'd3;

	localparam logic [1:0] ST_BUSY  = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_LENGTH   = 3'd1;
	localparam logic [2:0] ERR_PROTOCOL = 3'd2;
	localparam logic [2:0] ERR_RESERVED = 3'd3;
	localparam logic [2:0] ERR_HASH     = 3'd4;

	localparam logic [7:0] LENGTH_BYTE = 8'd19;
	localparam logic [4:0] PROTO_LAST  = 5'd18;
	localparam logic [2:0] RSVD_LAST   = 3'd7;
	localparam logic [4:0] FIELD_LAST  = 5'd19;

	typedef enum logic [4:0] {
		PH_LEN   = 5'b00001,
		PH_PROTO = 5'b00010,
		PH_RSVD  = 5'b00100,
		PH_HASH  = 5'b01000,
		PH_ID    = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [63:0] hash_high;
		logic [63:0] hash_mid;
		logic [31:0] hash_low;
		logic [63:0] reserved;
	} cfg_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] error_kind;
		logic       peer_id_valid;
		logic [4:0] peer_id_index;
		logic [7:0] peer_id_byte;
	} result_t;

	function automatic logic [7:0] proto_rom(input logic [4:0] idx);
		logic [7:0] b;
		unique case (idx)
			5'd0:    b = 8'h42;
			5'd1:    b = 8'h69;
			5'd2:    b = 8'h74;
			5'd3:    b = 8'h54;
			5'd4:    b = 8'h6f;
			5'd5:    b = 8'h72;
			5'd6:    b = 8'h72;
			5'd7:    b = 8'h65;
			5'd8:    b = 8'h6e;
			5'd9:    b = 8'h74;
			5'd10:   b = 8'h20;
			5'd11:   b = 8'h70;
			5'd12:   b = 8'h72;
			5'd13:   b = 8'h6f;
			5'd14:   b = 8'h74;
			5'd15:   b = 8'h6f;
			5'd16:   b = 8'h63;
			5'd17:   b = 8'h6f;
			5'd18:   b = 8'h6c;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/phc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// phc_cfg_regs
// Expected info hash and reserved bytes, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module phc_cfg_regs (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [phc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire  [phc_pkg::CFG_DATA_W-1:0]      cfg_data,
	output phc_pkg::cfg_t                       cfg
);
	import phc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HASH_HIGH: cfg_q.hash_high <= cfg_data;
				REG_HASH_MID:  cfg_q.hash_mid  <= cfg_data;
				REG_HASH_LOW:  cfg_q.hash_low  <= cfg_data[31:0];
				REG_RESERVED:  cfg_q.reserved  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/phc_checker.sv =====
// ----------------------------------------------------------------------------
// phc_checker
// Parser state and per-beat field compare; state advances on each step.
// ----------------------------------------------------------------------------
`default_nettype none

module phc_checker (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  wire  [7:0]           data_byte,
	input  wire  phc_pkg::cfg_t  cfg,
	output phc_pkg::result_t     result
);
	import phc_pkg::*;

	phase_t       phase_q;
	phase_t       phase_d;
	logic [4:0]   count_q;
	logic [4:0]   count_d;
	logic [2:0]   kind;
	logic [4:0]   proto_c;
	logic [2:0]   rsvd_c;
	logic [4:0]   long_c;
	logic [4:0]   hash_sel;
	logic [159:0] hash_vec;
	logic [7:0]   exp_rsvd;
	logic [7:0]   exp_hash;
	logic [7:0]   exp_proto;

	assign proto_c   = (count_q > PROTO_LAST) ? PROTO_LAST : count_q;
	assign rsvd_c    = (count_q > {2'b00, RSVD_LAST}) ? RSVD_LAST : count_q[2:0];
	assign long_c    = (count_q > FIELD_LAST) ? FIELD_LAST : count_q;
	assign hash_sel  = FIELD_LAST - long_c;
	assign hash_vec  = {cfg.hash_high, cfg.hash_mid, cfg.hash_low};
	assign exp_rsvd  = cfg.reserved[{~rsvd_c, 3'b000} +: 8];
	assign exp_hash  = hash_vec[{hash_sel, 3'b000} +: 8];
	assign exp_proto = proto_rom(proto_c);

	always_comb begin
		result  = '0;
		kind    = ERR_NONE;
		phase_d = phase_q;
		count_d = count_q;
		unique case (phase_q)
			PH_PROTO: begin
				if (data_byte != exp_proto) begin
					kind = ERR_PROTOCOL;
				end else if (proto_c == PROTO_LAST) begin
					phase_d = PH_RSVD;
					count_d = '0;
				end else begin
					count_d = proto_c + 5'd1;
				end
			end
			PH_RSVD: begin
				if (data_byte != exp_rsvd) begin
					kind = ERR_RESERVED;
				end else if (rsvd_c == RSVD_LAST) begin
					phase_d = PH_HASH;
					count_d = '0;
				end else begin
					count_d = {2'b00, rsvd_c} + 5'd1;
				end
			end
			PH_HASH: begin
				if (data_byte != exp_hash) begin
					kind = ERR_HASH;
				end else if (long_c == FIELD_LAST) begin
					phase_d = PH_ID;
					count_d = '0;
				end else begin
					count_d = long_c + 5'd1;
				end
			end
			PH_ID: begin
				result.peer_id_valid = 1'b1;
				result.peer_id_index = long_c;
				result.peer_id_byte  = data_byte;
				if (long_c == FIELD_LAST) begin
					result.status = ST_DONE;
					phase_d       = PH_LEN;
					count_d       = '0;
				end else begin
					count_d = long_c + 5'd1;
				end
			end
			default: begin
				if (data_byte != LENGTH_BYTE) begin
					kind = ERR_LENGTH;
				end else begin
					phase_d = PH_PROTO;
					count_d = '0;
				end
			end
		endcase
		if (kind != ERR_NONE) begin
			result        = '0;
			result.status = ST_ERROR;
			phase_d       = PH_LEN;
			count_d       = '0;
		end
		result.error_kind = kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIELD_LAST)
		else $error("byte count beyond last field position");

	a_error_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.status == ST_ERROR |=> phase_q == PH_LEN && count_q == 5'd0)
		else $error("parser not rewound after error");

endmodule

`default_nettype wire

// ===== hdl/peer_handshake_checker.sv =====
// ----------------------------------------------------------------------------
// peer_handshake_checker
// Checks a 68-byte peer handshake one beat at a time and reports per byte.
//
// Input channel: in_valid / in_stall with data_byte, one handshake byte a beat.
// Output channel: out_valid / out_stall with status, error_kind, peer_id_valid,
// peer_id_index and peer_id_byte, exactly one result beat per input beat.
// Configuration: cfg_we, cfg_index, cfg_data; index 0 hash bytes 0..7,
// 1 hash bytes 8..15, 2 hash bytes 16..19 (low 32 bits), 3 reserved bytes.
// Write only while no beat is in flight.
// Path: an accepted byte goes from the input register through the compare
// stage into the result register. Throughput: one byte per cycle unless
// out_stall holds a full result register, set by the single compare stage.
// Reset: clears configuration to zero, both pipeline valids and returns the
// parser to the length byte.
// Stall: a stalled result holds; the input register still takes a byte while
// the result register is full, and in_stall rises only once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_handshake_checker (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [phc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire  [phc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire  [7:0]                      data_byte,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic [1:0]                      status,
	output logic [2:0]                      error_kind,
	output logic                            peer_id_valid,
	output logic [4:0]                      peer_id_index,
	output logic [7:0]                      peer_id_byte
);
	import phc_pkg::*;

	cfg_t       cfg;
	result_t    result;
	result_t    result_s2;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	logic       out_free;
	logic       step;

	assign out_free = !valid_s2 || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	phc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	phc_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.cfg       (cfg),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign status        = result_s2.status;
	assign error_kind    = result_s2.error_kind;
	assign peer_id_valid = result_s2.peer_id_valid;
	assign peer_id_index = result_s2.peer_id_index;
	assign peer_id_byte  = result_s2.peer_id_byte;

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with a free stage");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ERROR |-> error_kind != ERR_NONE && !peer_id_valid)
		else $error("error beat carries peer id or no error kind");

	a_done_last_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DONE |-> peer_id_valid && peer_id_index == FIELD_LAST)
		else $error("completion not on last peer id byte");

endmodule

`default_nettype wire
